// ===== hw/rtl/acl_pkg.sv =====
package acl_pkg;

    localparam int VAL_W   = 26;
    localparam int WORD_W  = VAL_W + 1;
    localparam int UV_W    = 32;
    localparam int SET_W   = 33;
    localparam int SUM_W   = SET_W + 1;
    localparam int STEP_W  = 20;
    localparam int QUOT_W  = STEP_W;
    localparam int DIFF_W  = 26;
    localparam int NUM_W   = DIFF_W + STEP_W;
    localparam int DEN_W   = 30;
    localparam int DSH_W   = DEN_W + QUOT_W - 1;
    localparam int CNT_W   = $clog2(QUOT_W);

    localparam logic signed [UV_W-1:0]  SENTINEL_UV    = 32'sd999000000;
    localparam logic signed [UV_W-1:0]  UNCAL_LIMIT_UV = 32'sd900000000;
    localparam logic signed [VAL_W-1:0] CLAMP_POS_UV   = 26'sd9500000;
    localparam logic signed [VAL_W-1:0] CLAMP_NEG_UV   = -26'sd9500000;
    localparam logic signed [SUM_W-1:0] MATCH_POS_UV   = 34'sd10000;
    localparam logic signed [SUM_W-1:0] MATCH_NEG_UV   = -34'sd10000;
    localparam logic signed [SUM_W-1:0] OUT_MAX_UV     = 34'sd20000000;
    localparam logic signed [SUM_W-1:0] OUT_MIN_UV     = -34'sd20000000;

    localparam logic signed [VAL_W-1:0] GRID_BASE_RST  = -26'sd9500000;
    localparam logic [STEP_W-1:0]       GRID_STEP_RST  = 20'd50000;

    localparam logic [2:0] ST_INTERP   = 3'd0;
    localparam logic [2:0] ST_CLAMPED  = 3'd1;
    localparam logic [2:0] ST_PASS     = 3'd2;
    localparam logic [2:0] ST_DISABLED = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_WRITTEN  = 3'd5;
    localparam logic [2:0] ST_NOMATCH  = 3'd6;

    localparam logic [1:0] REG_CARD_ENABLE = 2'd0;
    localparam logic [1:0] REG_GRID_BASE   = 2'd1;
    localparam logic [1:0] REG_GRID_STEP   = 2'd2;

    localparam logic KIND_CAL  = 1'b0;
    localparam logic KIND_CONV = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CAL,
        S_LO,
        S_SEARCH,
        S_MUL,
        S_START,
        S_DIV
    } state_t;

    function automatic logic signed [UV_W-1:0] word_uv(input logic [WORD_W-1:0] w);
        logic signed [VAL_W-1:0] r;
        r = signed'(w[VAL_W-1:0]);
        return w[WORD_W-1] ? SENTINEL_UV : UV_W'(r);
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (c > OUT_MAX_UV)
        begin
            c = OUT_MAX_UV;
        end
        if (c < OUT_MIN_UV)
        begin
            c = OUT_MIN_UV;
        end
        return c[VAL_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/adc_calibration_linearizer.sv =====
// Calibration linearizer: one item is taken when start is high and busy is low.
// After reset the table sweep covers CARDS*CHANNELS*POINTS entries (25024 by
// default) with busy high; configuration writes are taken meanwhile. A
// calibrate item walks the grid one point per cycle. A convert item reads
// the channel's table one entry per cycle through the single table read
// port, one segment per cycle, then a 26x20 multiply and a 20-step restoring
// divider follow. Every item returns one result, shown on corrected/status
// for exactly one cycle with done high; it cannot be held off, so the
// receiver must take it in that cycle.
module adc_calibration_linearizer #(
    parameter int CARDS    = 8,
    parameter int CHANNELS = 8,
    parameter int POINTS   = 391
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic [2:0]         card,
    input  logic [2:0]         channel,
    input  logic signed [25:0] value,
    input  logic signed [25:0] reading,
    output logic               done,
    output logic signed [25:0] corrected,
    output logic [2:0]         status
);

    localparam int DEPTH  = CARDS * CHANNELS * POINTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int N_W    = $clog2(POINTS);

    logic [7:0]                                 enable_reg;
    logic signed [acl_pkg::VAL_W-1:0]           base_reg;
    logic [acl_pkg::STEP_W-1:0]                 step_reg;
    logic                                       cfg_wr;

    acl_pkg::state_t                            state_reg, state_next;
    logic                                       kind_reg;
    logic [2:0]                                 card_reg;
    logic [2:0]                                 chan_reg;
    logic signed [acl_pkg::VAL_W-1:0]           value_reg;
    logic signed [acl_pkg::VAL_W-1:0]           reading_reg;
    logic [ADDR_W-1:0]                          row_reg;
    logic [ADDR_W-1:0]                          addr_reg, addr_next;
    logic [N_W-1:0]                             n_reg, n_next;
    logic signed [acl_pkg::SET_W-1:0]           set_reg, set_next;
    logic signed [acl_pkg::UV_W-1:0]            lo_reg, lo_next;
    logic [acl_pkg::DIFF_W-1:0]                 diff_reg, diff_next;
    logic [acl_pkg::DEN_W-1:0]                  den_reg, den_next;
    logic [acl_pkg::NUM_W-1:0]                  prod_reg;

    logic                                       done_reg, done_next;
    logic signed [acl_pkg::VAL_W-1:0]           corr_reg, corr_next;
    logic [2:0]                                 status_reg, status_next;

    logic                                       accept;
    logic                                       tbl_ready;
    logic [ADDR_W-1:0]                          rd_addr;
    logic [acl_pkg::WORD_W-1:0]                 rd_data;
    logic                                       wr_en;
    logic [ADDR_W-1:0]                          wr_addr;
    logic                                       div_start;
    logic                                       div_done;
    logic [acl_pkg::QUOT_W-1:0]                 quot;

    logic signed [acl_pkg::UV_W-1:0]            value_uv;
    logic signed [acl_pkg::UV_W-1:0]            rd_uv;
    logic signed [acl_pkg::SET_W-1:0]           base_set;
    logic signed [acl_pkg::SET_W-1:0]           step_set;
    logic signed [acl_pkg::SUM_W-1:0]           cal_diff;
    logic                                       in_range;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            base_reg   <= acl_pkg::GRID_BASE_RST;
            step_reg   <= acl_pkg::GRID_STEP_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                acl_pkg::REG_CARD_ENABLE: enable_reg <= pwdata[7:0];
                acl_pkg::REG_GRID_BASE:   base_reg   <= signed'(pwdata[acl_pkg::VAL_W-1:0]);
                acl_pkg::REG_GRID_STEP:   step_reg   <= pwdata[acl_pkg::STEP_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            acl_pkg::REG_CARD_ENABLE: prdata = {24'd0, enable_reg};
            acl_pkg::REG_GRID_BASE:   prdata = 32'(base_reg);
            acl_pkg::REG_GRID_STEP:   prdata = {12'd0, step_reg};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign busy   = (state_reg != acl_pkg::S_IDLE) | ~tbl_ready;
    assign accept = start & ~busy;

    assign value_uv = acl_pkg::UV_W'(value_reg);
    assign rd_uv    = acl_pkg::word_uv(rd_data);
    assign base_set = acl_pkg::SET_W'(base_reg);
    assign step_set = signed'(acl_pkg::SET_W'(step_reg));
    assign cal_diff = acl_pkg::SUM_W'(value_reg) - acl_pkg::SUM_W'(set_reg);
    assign in_range = (32'(card_reg) < 32'(CARDS)) && (32'(chan_reg) < 32'(CHANNELS));
    assign wr_addr  = row_reg + ADDR_W'(n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acl_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            card_reg    <= card;
            chan_reg    <= channel;
            value_reg   <= value;
            reading_reg <= reading;
            row_reg     <= ADDR_W'((32'(card) * 32'(CHANNELS) + 32'(channel)) * 32'(POINTS));
        end
        addr_reg   <= addr_next;
        n_reg      <= n_next;
        set_reg    <= set_next;
        lo_reg     <= lo_next;
        diff_reg   <= diff_next;
        den_reg    <= den_next;
        prod_reg   <= acl_pkg::NUM_W'(diff_reg) * acl_pkg::NUM_W'(step_reg);
        corr_reg   <= corr_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        n_next      = n_reg;
        set_next    = set_reg;
        lo_next     = lo_reg;
        diff_next   = diff_reg;
        den_next    = den_reg;
        done_next   = 1'b0;
        corr_next   = corr_reg;
        status_next = status_reg;
        rd_addr     = addr_reg;
        wr_en       = 1'b0;
        div_start   = 1'b0;

        case (state_reg)
            acl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = acl_pkg::S_CHECK;
                end
            end

            acl_pkg::S_CHECK:
            begin
                n_next   = '0;
                set_next = base_set;
                if (kind_reg == acl_pkg::KIND_CAL)
                begin
                    if (in_range)
                    begin
                        state_next = acl_pkg::S_CAL;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        corr_next   = '0;
                        status_next = acl_pkg::ST_NOMATCH;
                        state_next  = acl_pkg::S_IDLE;
                    end
                end
                else if (!in_range || !enable_reg[card_reg])
                begin
                    done_next   = 1'b1;
                    corr_next   = '0;
                    status_next = acl_pkg::ST_DISABLED;
                    state_next  = acl_pkg::S_IDLE;
                end
                else if (value_reg < acl_pkg::CLAMP_NEG_UV)
                begin
                    done_next   = 1'b1;
                    corr_next   = acl_pkg::CLAMP_NEG_UV;
                    status_next = acl_pkg::ST_CLAMPED;
                    state_next  = acl_pkg::S_IDLE;
                end
                else if (value_reg > acl_pkg::CLAMP_POS_UV)
                begin
                    done_next   = 1'b1;
                    corr_next   = acl_pkg::CLAMP_POS_UV;
                    status_next = acl_pkg::ST_CLAMPED;
                    state_next  = acl_pkg::S_IDLE;
                end
                else
                begin
                    rd_addr    = row_reg;
                    state_next = acl_pkg::S_LO;
                end
            end

            acl_pkg::S_CAL:
            begin
                if (cal_diff > acl_pkg::MATCH_NEG_UV && cal_diff < acl_pkg::MATCH_POS_UV)
                begin
                    wr_en       = 1'b1;
                    done_next   = 1'b1;
                    corr_next   = '0;
                    status_next = acl_pkg::ST_WRITTEN;
                    state_next  = acl_pkg::S_IDLE;
                end
                else if (n_reg == N_W'(POINTS - 1))
                begin
                    done_next   = 1'b1;
                    corr_next   = '0;
                    status_next = acl_pkg::ST_NOMATCH;
                    state_next  = acl_pkg::S_IDLE;
                end
                else
                begin
                    n_next   = n_reg + 1'b1;
                    set_next = set_reg + step_set;
                end
            end

            acl_pkg::S_LO:
            begin
                if (rd_uv > acl_pkg::UNCAL_LIMIT_UV)
                begin
                    done_next   = 1'b1;
                    corr_next   = value_reg;
                    status_next = acl_pkg::ST_PASS;
                    state_next  = acl_pkg::S_IDLE;
                end
                else
                begin
                    lo_next    = rd_uv;
                    rd_addr    = row_reg + ADDR_W'(1);
                    addr_next  = row_reg + ADDR_W'(2);
                    state_next = acl_pkg::S_SEARCH;
                end
            end

            acl_pkg::S_SEARCH:
            begin
                // rd_data holds the upper end of segment n_reg
                if (value_uv >= lo_reg && value_uv <= rd_uv)
                begin
                    if (rd_uv == lo_reg)
                    begin
                        done_next   = 1'b1;
                        corr_next   = acl_pkg::sat_out(acl_pkg::SUM_W'(set_reg));
                        status_next = acl_pkg::ST_INTERP;
                        state_next  = acl_pkg::S_IDLE;
                    end
                    else
                    begin
                        diff_next  = acl_pkg::DIFF_W'(value_uv - lo_reg);
                        den_next   = acl_pkg::DEN_W'(rd_uv - lo_reg);
                        state_next = acl_pkg::S_MUL;
                    end
                end
                else if (n_reg == N_W'(POINTS - 2))
                begin
                    done_next   = 1'b1;
                    corr_next   = '0;
                    status_next = acl_pkg::ST_NOTFOUND;
                    state_next  = acl_pkg::S_IDLE;
                end
                else
                begin
                    lo_next   = rd_uv;
                    n_next    = n_reg + 1'b1;
                    set_next  = set_reg + step_set;
                    addr_next = addr_reg + 1'b1;
                end
            end

            acl_pkg::S_MUL:
            begin
                state_next = acl_pkg::S_START;
            end

            acl_pkg::S_START:
            begin
                div_start  = 1'b1;
                state_next = acl_pkg::S_DIV;
            end

            acl_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    done_next   = 1'b1;
                    corr_next   = acl_pkg::sat_out(acl_pkg::SUM_W'(set_reg)
                                  + signed'(acl_pkg::SUM_W'(quot)));
                    status_next = acl_pkg::ST_INTERP;
                    state_next  = acl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = acl_pkg::S_IDLE;
            end
        endcase
    end

    acl_table #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (reading_reg),
        .ready   (tbl_ready)
    );

    acl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    assign done      = done_reg;
    assign corrected = corr_reg;
    assign status    = status_reg;

endmodule

// ===== hw/rtl/acl_table.sv =====
module acl_table #(
    parameter int DEPTH  = 25024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [acl_pkg::WORD_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [acl_pkg::VAL_W-1:0]  wr_data,
    output logic                       ready
);

    logic [acl_pkg::WORD_W-1:0] mem [DEPTH];
    logic [acl_pkg::WORD_W-1:0] rd_data_reg;
    logic                       clr_reg;
    logic [ADDR_W-1:0]          clr_addr_reg;
    logic                       we;
    logic [ADDR_W-1:0]          wa;
    logic [acl_pkg::WORD_W-1:0] wd;

    // sweep after reset: every entry gets the sentinel flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        we = clr_reg | wr_en;
        wa = clr_reg ? clr_addr_reg : wr_addr;
        wd = clr_reg ? {1'b1, {acl_pkg::VAL_W{1'b0}}} : {1'b0, wr_data};
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = ~clr_reg;

endmodule

// ===== hw/rtl/acl_div.sv =====
module acl_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [acl_pkg::NUM_W-1:0]  num,
    input  logic [acl_pkg::DEN_W-1:0]  den,
    output logic                       done,
    output logic [acl_pkg::QUOT_W-1:0] quot
);

    logic                       active_reg;
    logic                       done_reg;
    logic [acl_pkg::CNT_W-1:0]  cnt_reg;
    logic [acl_pkg::NUM_W-1:0]  rem_reg;
    logic [acl_pkg::DSH_W-1:0]  dsh_reg;
    logic [acl_pkg::QUOT_W-1:0] quot_reg;
    logic                       ge;

    // quotient is known to fit QUOT_W bits, so only that many restoring steps
    assign ge = acl_pkg::DSH_W'(rem_reg) >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == acl_pkg::CNT_W'(acl_pkg::QUOT_W - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            dsh_reg  <= {den, {(acl_pkg::QUOT_W - 1){1'b0}}};
            quot_reg <= '0;
        end
        else if (active_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg[acl_pkg::NUM_W-1:0];
            end
            quot_reg <= {quot_reg[acl_pkg::QUOT_W-2:0], ge};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hw/rtl/acl_checker.sv =====
module acl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [25:0] corrected,
    input logic [2:0]         status
);

    // an accepted beat keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // a result only follows work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= acl_pkg::ST_NOMATCH))
        else $error("undefined status code");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == acl_pkg::ST_DISABLED || status == acl_pkg::ST_NOTFOUND
                  || status == acl_pkg::ST_WRITTEN || status == acl_pkg::ST_NOMATCH))
        |-> (corrected == 26'sd0))
        else $error("nonzero corrected on a no-value status");

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == acl_pkg::ST_CLAMPED)
        |-> (corrected == acl_pkg::CLAMP_POS_UV || corrected == acl_pkg::CLAMP_NEG_UV))
        else $error("clamped result off the clamp limits");

endmodule

bind adc_calibration_linearizer acl_checker u_acl_checker (.*);
